### rtl/skset_pkg.sv
// Package for the sorted key set: payload structs, codes, states and defaults.
package skset_pkg;

  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 16;

  localparam int KEY_FIELD_W   = 16;
  localparam int POS_FIELD_W   = 6;
  localparam int COUNT_FIELD_W = 7;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_FIND   = 2'd2,
    CMD_CLEAR  = 2'd3
  } command_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_t;

  typedef struct packed {
    command_t                 command;
    logic [KEY_FIELD_W-1:0]   key;
  } item_t;

  typedef struct packed {
    status_t                  status;
    logic                     found;
    logic [POS_FIELD_W-1:0]   position;
    logic [COUNT_FIELD_W-1:0] count;
  } result_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_INS_LAST,
    S_INS_FIRST,
    S_INS_TEST,
    S_INS_CMP,
    S_SHUP_TEST,
    S_SHUP_WR,
    S_INS_WR,
    S_LOC_TEST,
    S_LOC_CMP,
    S_LOC_LO,
    S_LOC_HI,
    S_SHDN_TEST,
    S_SHDN_WR,
    S_DONE
  } state_t;

endpackage

### rtl/sorted_key_set.sv
// Sorted key set: ordered key table in a memory, searched and shifted by a small sequencer.
//
// One command is taken while busy is low; busy stays high until the single result has been
// shown for one cycle with done high, and that result cannot be held off by the receiver.
// Every step goes through one synchronous read port of the key memory and one key compare
// unit. The next command can be taken in the cycle after the result cycle. Clear, a find or
// delete on an empty table and an insert into a full table go straight to the result; an
// insert into an empty table writes the key first. With n keys held a search makes up to
// ceil(log2(n-1)) probes (none for one key); delete then moves each entry above the removed
// one down, and insert moves each larger entry up (none when the key goes to the end, all
// when it goes below the first entry). The memory needs no clearing after reset.
module sorted_key_set #(
  parameter int CAPACITY  = skset_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = skset_pkg::KEY_WIDTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  skset_pkg::item_t   item,
  output logic              done,
  output skset_pkg::result_t result
);
  import skset_pkg::*;

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  // key memory
  logic [KEY_WIDTH-1:0] keys [CAPACITY];
  logic [KEY_WIDTH-1:0] rdata;
  logic [IDX_W-1:0]     raddr;
  logic [IDX_W-1:0]     waddr;
  logic [KEY_WIDTH-1:0] wdata;
  logic                 mem_we;

  state_t               state, state_next;
  command_t             cmd;
  logic [KEY_WIDTH-1:0] key_val;
  logic [IDX_W-1:0]     lo, lo_next;
  logic [IDX_W-1:0]     hi, hi_next;
  logic [IDX_W-1:0]     mid, mid_next;
  logic [IDX_W-1:0]     idx, idx_next;
  logic [IDX_W-1:0]     pos, pos_next;
  logic [CNT_W-1:0]     element_count, element_count_next;
  status_t              res_status, res_status_next;
  logic                 res_found, res_found_next;

  logic                 accept;
  logic [IDX_W:0]       lohi_sum;
  logic [IDX_W-1:0]     mid_calc;
  logic                 span_wide;
  logic [IDX_W-1:0]     last_idx;
  logic                 key_eq, key_gt, key_lt;

  assign accept    = start && !busy;
  assign lohi_sum  = {1'b0, lo} + {1'b0, hi};
  assign mid_calc  = lohi_sum[IDX_W:1];
  assign span_wide = (hi - lo) > IDX_W'(1);
  assign last_idx  = IDX_W'(element_count - CNT_W'(1));

  // shared compare unit: latched key against the word just read
  assign key_eq = key_val == rdata;
  assign key_gt = key_val > rdata;
  assign key_lt = key_val < rdata;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      keys[waddr] <= wdata;
    end
    rdata <= keys[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      element_count <= '0;
    end else begin
      state         <= state_next;
      element_count <= element_count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd     <= item.command;
      key_val <= KEY_WIDTH'(item.key);
    end
    lo         <= lo_next;
    hi         <= hi_next;
    mid        <= mid_next;
    idx        <= idx_next;
    pos        <= pos_next;
    res_status <= res_status_next;
    res_found  <= res_found_next;
  end

  always_comb begin
    state_next         = state;
    lo_next            = lo;
    hi_next            = hi;
    mid_next           = mid;
    idx_next           = idx;
    pos_next           = pos;
    element_count_next = element_count;
    res_status_next    = res_status;
    res_found_next     = res_found;
    raddr              = mid;
    waddr              = idx;
    wdata              = rdata;
    mem_we             = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (accept) begin
          res_status_next = ST_DONE;
          res_found_next  = 1'b0;
          pos_next        = '0;
          lo_next         = '0;
          hi_next         = last_idx;
          unique case (item.command)
            CMD_INSERT: begin
              if (element_count == CNT_W'(CAPACITY)) begin
                res_status_next = ST_FULL;
                state_next      = S_DONE;
              end else if (element_count == '0) begin
                state_next = S_INS_WR;
              end else begin
                raddr      = last_idx;
                state_next = S_INS_LAST;
              end
            end
            CMD_DELETE, CMD_FIND: begin
              if (element_count == '0) begin
                res_status_next = ST_NOT_FOUND;
                state_next      = S_DONE;
              end else begin
                state_next = S_LOC_TEST;
              end
            end
            CMD_CLEAR: begin
              element_count_next = '0;
              state_next         = S_DONE;
            end
            default: state_next = S_DONE;
          endcase
        end
      end

      // insert: slot search
      S_INS_LAST: begin
        if (key_gt) begin
          pos_next   = IDX_W'(element_count);
          idx_next   = IDX_W'(element_count);
          state_next = S_SHUP_TEST;
        end else begin
          raddr      = '0;
          state_next = S_INS_FIRST;
        end
      end
      S_INS_FIRST: begin
        if (key_lt) begin
          pos_next   = '0;
          idx_next   = IDX_W'(element_count);
          state_next = S_SHUP_TEST;
        end else begin
          state_next = S_INS_TEST;
        end
      end
      S_INS_TEST: begin
        if (span_wide) begin
          mid_next   = mid_calc;
          raddr      = mid_calc;
          state_next = S_INS_CMP;
        end else begin
          pos_next   = lo + IDX_W'(1);
          idx_next   = IDX_W'(element_count);
          state_next = S_SHUP_TEST;
        end
      end
      S_INS_CMP: begin
        if (!key_gt) begin
          hi_next = mid;
        end else begin
          lo_next = mid;
        end
        state_next = S_INS_TEST;
      end

      // insert: move larger entries up one slot, top first
      S_SHUP_TEST: begin
        if (idx > pos) begin
          raddr      = idx - IDX_W'(1);
          state_next = S_SHUP_WR;
        end else begin
          state_next = S_INS_WR;
        end
      end
      S_SHUP_WR: begin
        mem_we     = 1'b1;
        waddr      = idx;
        wdata      = rdata;
        idx_next   = idx - IDX_W'(1);
        state_next = S_SHUP_TEST;
      end
      S_INS_WR: begin
        mem_we             = 1'b1;
        waddr              = pos;
        wdata              = key_val;
        element_count_next = element_count + CNT_W'(1);
        res_found_next     = 1'b1;
        state_next         = S_DONE;
      end

      // find and delete: binary search
      S_LOC_TEST: begin
        if (span_wide) begin
          mid_next   = mid_calc;
          raddr      = mid_calc;
          state_next = S_LOC_CMP;
        end else begin
          raddr      = lo;
          state_next = S_LOC_LO;
        end
      end
      S_LOC_CMP: begin
        if (key_eq) begin
          pos_next   = mid;
          idx_next   = mid;
          state_next = (cmd == CMD_DELETE) ? S_SHDN_TEST : S_DONE;
          res_found_next = 1'b1;
        end else begin
          if (key_lt) begin
            hi_next = mid;
          end else begin
            lo_next = mid;
          end
          state_next = S_LOC_TEST;
        end
      end
      S_LOC_LO: begin
        if (key_eq) begin
          pos_next       = lo;
          idx_next       = lo;
          res_found_next = 1'b1;
          state_next     = (cmd == CMD_DELETE) ? S_SHDN_TEST : S_DONE;
        end else begin
          raddr      = hi;
          state_next = S_LOC_HI;
        end
      end
      S_LOC_HI: begin
        if (key_eq) begin
          pos_next       = hi;
          idx_next       = hi;
          res_found_next = 1'b1;
          state_next     = (cmd == CMD_DELETE) ? S_SHDN_TEST : S_DONE;
        end else begin
          res_status_next = ST_NOT_FOUND;
          state_next      = S_DONE;
        end
      end

      // delete: close the gap, bottom first
      S_SHDN_TEST: begin
        if ((CNT_W'(idx) + CNT_W'(1)) < element_count) begin
          raddr      = idx + IDX_W'(1);
          state_next = S_SHDN_WR;
        end else begin
          element_count_next = element_count - CNT_W'(1);
          state_next         = S_DONE;
        end
      end
      S_SHDN_WR: begin
        mem_we     = 1'b1;
        waddr      = idx;
        wdata      = rdata;
        idx_next   = idx + IDX_W'(1);
        state_next = S_SHDN_TEST;
      end

      S_DONE: begin
        state_next = S_IDLE;
      end

      default: state_next = S_IDLE;
    endcase
  end

  assign busy            = state != S_IDLE;
  assign done            = state == S_DONE;
  assign result.status   = res_status;
  assign result.found    = res_found;
  assign result.position = res_found ? POS_FIELD_W'(pos) : '0;
  assign result.count    = COUNT_FIELD_W'(element_count);

endmodule
